[hw/rtl/pct_pkg.sv]
// pct_pkg: shared types and constants for the peer candidate table
// holds the operation codes, the table entry layout and field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

    localparam int ADDR_W     = 48;
    localparam int AKIND_W    = 2;
    localparam int STRENGTH_W = 8;
    localparam int TIME_W     = 32;
    localparam int DKIND_W    = 2;
    localparam int LIMIT_W    = 16;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 4;

    // packed stream widths, rounded up to whole bytes
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 120;

    localparam logic [LIMIT_W-1:0] STALE_RESET = 16'd15000;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_PRUNE  = 2'd1,
        OP_SELECT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [ADDR_W-1:0]            addr;
        logic [AKIND_W-1:0]           akind;
        logic signed [STRENGTH_W-1:0] strength;
        logic [TIME_W-1:0]            seen;
        logic [DKIND_W-1:0]           dkind;
    } t_entry;

endpackage

`default_nettype wire

[hw/rtl/peer_candidate_table.sv]
// peer_candidate_table: table of advertising peers walked by a small sequencer
// holds the entry memory, one shared age subtractor and the scan control
// depends on pct_pkg
//
// Usage: items enter on the s-side stream (i_s_tvalid/o_s_tready); tuser carries
// the operation (record, prune, select, or an unused code that only reports).
// Each item gives exactly one result on the m-side stream. The stale limit is
// written on the cfg channel; the user must do so only while the block is idle,
// which the block itself does not enforce; o_cfg_ready is always high.
// The table sits in a single-port memory, one entry read at a time (read, then
// evaluate through one shared age subtractor and comparators).
// Steps per item: record scans for a matching address, else appends, and on a
// full table makes a second pass to replace the oldest entry; prune and select
// scan every valid entry (none on an empty table); an unused op only reports.
// The block takes one item at a time; o_s_tready is high only when idle,
// which comes back in the same cycle that the result goes valid.
// A finished result sits in the output register: the next item is accepted
// while it waits, and that item's result is held back until the first is taken.
// Reset empties the table, clears the last-known peer and sets the stale limit
// to 15000 ms; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module peer_candidate_table #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // cfg write channel: stale_limit_ms
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [pct_pkg::LIMIT_W-1:0]  i_cfg_data,
    // input stream
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    // tdata from bit 0: peer_address[47:0], peer_address_kind[49:48],
    // signal_strength[57:50], device_kind[59:58], now_ms[91:60], zero pad
    input  wire [pct_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: op[1:0]
    input  wire [1:0]                   i_s_tuser,
    // output stream
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    // tdata from bit 0: slot[2:0], entry_count[6:3], was_update[7], found[8],
    // best_address[56:9], best_address_kind[58:57], best_strength[66:59],
    // best_kind[68:67], last_known_address[116:69], last_known_valid[117], zero pad
    output logic [pct_pkg::M_DATA_W-1:0] o_m_tdata
);
    import pct_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                r_state;
    t_op                   r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic [AKIND_W-1:0]    r_akind;
    logic [STRENGTH_W-1:0] r_strength;
    logic [DKIND_W-1:0]    r_dkind;
    logic [TIME_W-1:0]     r_now;
    logic [LIMIT_W-1:0]    r_stale_limit;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_wr_idx;
    logic [IDX_W-1:0]      r_slot;
    logic                  r_was_update;
    logic                  r_found;
    logic                  r_age_scan;
    logic [TIME_W-1:0]     r_oldest;
    t_entry                r_best;
    logic [ADDR_W-1:0]     r_known_addr;
    logic                  r_known_valid;
    logic                  r_m_valid;
    logic [M_DATA_W-1:0]   r_m_data;

    t_entry                r_mem [TABLE_DEPTH];
    t_entry                r_rd_data;

    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    t_entry                w_wr_data;
    logic [TIME_W-1:0]     w_age;
    logic                  w_keep;
    logic                  w_last;
    logic                  w_full;
    logic                  w_stronger;
    logic [IDX_W+2:0]      w_slot_ext;
    logic [CNT_W+3:0]      w_cnt_ext;
    logic [M_DATA_W-1:0]   n_m_data;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    // shared age unit: wrapping difference against the entry just read
    assign w_age      = r_now - r_rd_data.seen;
    assign w_keep     = (w_age <= {{(TIME_W-LIMIT_W){1'b0}}, r_stale_limit});
    assign w_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_stronger = ($signed(r_rd_data.strength) > $signed(r_best.strength));

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot;
        w_wr_data = r_rd_data;
        if (r_state == S_EVAL && r_op == OP_PRUNE && w_keep) begin
            // compact kept entries toward slot 0
            w_wr_en   = 1'b1;
            w_wr_addr = r_wr_idx[IDX_W-1:0];
        end else if (r_state == S_WRITE) begin
            w_wr_en            = 1'b1;
            w_wr_data.addr     = r_addr;
            w_wr_data.akind    = r_was_update ? r_rd_data.akind : r_akind;
            w_wr_data.strength = r_strength;
            w_wr_data.seen     = r_now;
            w_wr_data.dkind    = r_dkind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign w_slot_ext = {3'b000, r_slot};
    assign w_cnt_ext  = {4'b0000, r_count};

    always_comb begin
        n_m_data         = '0;
        n_m_data[2:0]    = w_slot_ext[SLOT_W-1:0];
        n_m_data[6:3]    = w_cnt_ext[COUNT_W-1:0];
        n_m_data[7]      = r_was_update;
        n_m_data[8]      = r_found;
        if (r_found) begin
            n_m_data[56:9]  = r_best.addr;
            n_m_data[58:57] = r_best.akind;
            n_m_data[66:59] = r_best.strength;
            n_m_data[68:67] = r_best.dkind;
        end
        n_m_data[116:69] = r_known_addr;
        n_m_data[117]    = r_known_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_op          <= OP_NONE;
            r_stale_limit <= STALE_RESET;
            r_count       <= '0;
            r_idx         <= '0;
            r_wr_idx      <= '0;
            r_slot        <= '0;
            r_was_update  <= 1'b0;
            r_found       <= 1'b0;
            r_age_scan    <= 1'b0;
            r_oldest      <= '0;
            r_known_addr  <= '0;
            r_known_valid <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_stale_limit <= i_cfg_data;
            end
            // in S_DONE the output register is reloaded below instead
            if (r_m_valid && i_m_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op         <= t_op'(i_s_tuser);
                        r_addr       <= i_s_tdata[47:0];
                        r_akind      <= i_s_tdata[49:48];
                        r_strength   <= i_s_tdata[57:50];
                        r_dkind      <= i_s_tdata[59:58];
                        r_now        <= i_s_tdata[91:60];
                        r_idx        <= '0;
                        r_wr_idx     <= '0;
                        r_slot       <= '0;
                        r_was_update <= 1'b0;
                        r_found      <= 1'b0;
                        r_age_scan   <= 1'b0;
                        r_oldest     <= '0;
                        unique case (t_op'(i_s_tuser))
                            OP_RECORD: begin
                                if (r_count == '0) begin
                                    r_count <= CNT_W'(1);
                                    r_state <= S_WRITE;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            OP_PRUNE, OP_SELECT: begin
                                r_state <= (r_count == '0) ? S_DONE : S_READ;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_READ: begin
                    r_state <= S_EVAL;
                end

                S_EVAL: begin
                    unique case (r_op)
                        OP_RECORD: begin
                            if (!r_age_scan) begin
                                if (r_rd_data.addr == r_addr) begin
                                    r_slot       <= r_idx;
                                    r_was_update <= 1'b1;
                                    r_state      <= S_WRITE;
                                end else if (w_last && !w_full) begin
                                    r_slot  <= r_count[IDX_W-1:0];
                                    r_count <= r_count + CNT_W'(1);
                                    r_state <= S_WRITE;
                                end else if (w_last) begin
                                    // full table: second pass looks for the oldest entry
                                    r_age_scan <= 1'b1;
                                    r_idx      <= '0;
                                    r_state    <= S_READ;
                                end else begin
                                    r_idx   <= r_idx + IDX_W'(1);
                                    r_state <= S_READ;
                                end
                            end else begin
                                if (w_age > r_oldest) begin
                                    r_oldest <= w_age;
                                    r_slot   <= r_idx;
                                end
                                if (r_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                                    r_state <= S_WRITE;
                                end else begin
                                    r_idx   <= r_idx + IDX_W'(1);
                                    r_state <= S_READ;
                                end
                            end
                        end
                        OP_PRUNE: begin
                            if (w_keep) begin
                                r_wr_idx <= r_wr_idx + CNT_W'(1);
                            end
                            if (w_last) begin
                                r_count <= w_keep ? r_wr_idx + CNT_W'(1) : r_wr_idx;
                                r_state <= S_DONE;
                            end else begin
                                r_idx   <= r_idx + IDX_W'(1);
                                r_state <= S_READ;
                            end
                        end
                        OP_SELECT: begin
                            // the strongest entry wins; on a tie the first one stays
                            if (r_idx == '0 || w_stronger) begin
                                r_best <= r_rd_data;
                                r_slot <= r_idx;
                            end
                            r_found <= 1'b1;
                            if (w_last) begin
                                r_state <= S_DONE;
                            end else begin
                                r_idx   <= r_idx + IDX_W'(1);
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end

                S_WRITE: begin
                    if (!r_was_update) begin
                        r_known_addr  <= r_addr;
                        r_known_valid <= 1'b1;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_data  <= n_m_data;
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for the peer candidate table
// streams record/prune/select items and stale-limit writes, mirrors the table in a class
// depends on pct_pkg and peer_candidate_table
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import pct_pkg::*;

    localparam int DEPTH          = 8;
    localparam int POOL_SIZE      = 12;
    localparam int PHASE_ITEMS    = 290;
    localparam int IDLE_LIMIT     = 2000;
    localparam int TAIL_CYCLES    = 4 * DEPTH + 8;
    localparam int MAX_REPORTS    = 200;

    typedef struct {
        logic [SLOT_W-1:0]     slot;
        logic [COUNT_W-1:0]    count;
        logic                  was_update;
        logic                  found;
        logic [ADDR_W-1:0]     best_addr;
        logic [AKIND_W-1:0]    best_akind;
        logic [STRENGTH_W-1:0] best_strength;
        logic [DKIND_W-1:0]    best_dkind;
        logic [ADDR_W-1:0]     known_addr;
        logic                  known_valid;
    } t_report;

    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_HOLD   = 2'd3
    } t_rx_mode;

    // mirror of the peer table; queues the report each accepted item should produce
    class peer_table_mirror;
        t_entry             entries [DEPTH];
        int unsigned        live;
        logic [ADDR_W-1:0]  known_addr;
        logic               known_valid;
        logic [LIMIT_W-1:0] stale_limit;
        t_report            pending_reports [$];
        int unsigned        mismatches;

        function new();
            foreach (entries[i]) entries[i] = '0;
            live        = 0;
            known_addr  = '0;
            known_valid = 1'b0;
            stale_limit = STALE_RESET;
            mismatches  = 0;
        endfunction

        function void write_limit(logic [LIMIT_W-1:0] value);
            stale_limit = value;
        endfunction

        function void take_item(logic [1:0] op_bits, logic [S_DATA_W-1:0] data);
            t_entry            item;
            t_report           rep;
            logic [TIME_W-1:0] age;
            logic [TIME_W-1:0] oldest;
            int unsigned       i;
            int unsigned       hit;
            int unsigned       kept;
            int unsigned       best;
            bit                matched;
            item.addr     = data[47:0];
            item.akind    = data[49:48];
            item.strength = data[57:50];
            item.dkind    = data[59:58];
            item.seen     = data[91:60];
            rep           = '{default: '0};
            matched       = 1'b0;
            hit           = 0;
            case (t_op'(op_bits))
                OP_RECORD: begin
                    for (i = 0; i < live && !matched; i++) begin
                        if (entries[i].addr == item.addr) begin
                            hit     = i;
                            matched = 1'b1;
                        end
                    end
                    if (matched) begin
                        // address type of a known peer is kept
                        entries[hit].strength = item.strength;
                        entries[hit].seen     = item.seen;
                        entries[hit].dkind    = item.dkind;
                        rep.was_update        = 1'b1;
                    end else begin
                        if (live >= DEPTH) begin
                            // first strictly oldest entry, slot 0 when all ages are zero
                            oldest = '0;
                            for (i = 0; i < DEPTH; i++) begin
                                age = item.seen - entries[i].seen;
                                if (age > oldest) begin
                                    oldest = age;
                                    hit    = i;
                                end
                            end
                        end else begin
                            hit  = live;
                            live = live + 1;
                        end
                        entries[hit] = item;
                        known_addr   = item.addr;
                        known_valid  = 1'b1;
                    end
                    rep.slot = SLOT_W'(hit);
                end
                OP_PRUNE: begin
                    kept = 0;
                    for (i = 0; i < live; i++) begin
                        age = item.seen - entries[i].seen;
                        if (age <= {16'd0, stale_limit}) begin
                            entries[kept] = entries[i];
                            kept          = kept + 1;
                        end
                    end
                    live = kept;
                end
                OP_SELECT: begin
                    if (live > 0) begin
                        best = 0;
                        for (i = 1; i < live; i++) begin
                            if ($signed(entries[i].strength) > $signed(entries[best].strength))
                                best = i;
                        end
                        rep.slot          = SLOT_W'(best);
                        rep.found         = 1'b1;
                        rep.best_addr     = entries[best].addr;
                        rep.best_akind    = entries[best].akind;
                        rep.best_strength = entries[best].strength;
                        rep.best_dkind    = entries[best].dkind;
                    end
                end
                default: begin
                end
            endcase
            rep.count       = COUNT_W'(live);
            rep.known_addr  = known_addr;
            rep.known_valid = known_valid;
            pending_reports.push_back(rep);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            t_report want;
            if (pending_reports.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, data);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            check_field("slot", want.slot, data[2:0]);
            check_field("entry_count", want.count, data[6:3]);
            check_field("was_update", want.was_update, data[7]);
            check_field("found", want.found, data[8]);
            check_field("best_address", want.best_addr, data[56:9]);
            check_field("best_address_kind", want.best_akind, data[58:57]);
            check_field("best_strength", want.best_strength, data[66:59]);
            check_field("best_kind", want.best_dkind, data[68:67]);
            check_field("last_known_address", want.known_addr, data[116:69]);
            check_field("last_known_valid", want.known_valid, data[117]);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [LIMIT_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [1:0]            s_tuser   = OP_RECORD;
    logic                  m_tready  = 1'b1;
    wire                   cfg_ready;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [M_DATA_W-1:0]   m_tdata;

    peer_table_mirror      mirror;
    int unsigned           burst_left = 1;
    int unsigned           quiet      = 0;
    t_rx_mode              rx_mode    = RX_OPEN;
    int unsigned           rx_left    = 0;
    int unsigned           rx_tick    = 0;

    always #1 clk = ~clk;

    peer_candidate_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    // sample every handshake at the edge it completes on
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                mirror.check_result(m_tdata);
            if (s_tvalid && s_tready)
                mirror.take_item(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                mirror.write_limit(cfg_data);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (m_tvalid && m_tready) || (s_tvalid && s_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // receiver: open, coin-flip, one-in-four and solid stall stretches
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(20, 200);
        end
        rx_left = rx_left - 1;
        rx_tick = rx_tick + 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] addr,
                             input logic [1:0] akind, input logic [7:0] strength,
                             input logic [1:0] dkind, input logic [31:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, now, dkind, strength, akind, addr};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic hold_off(input int unsigned cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // sender bursts: mostly short, now and then a long unbroken run
    task automatic pace();
        if (burst_left > 0)
            burst_left = burst_left - 1;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            hold_off($urandom_range(1, 12));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (mirror.pending_reports.size() != 0);
    endtask

    task automatic set_stale_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [ADDR_W-1:0]  dir_addr [DEPTH];
        logic [7:0]         dir_strength [DEPTH];
        logic [ADDR_W-1:0]  pool [POOL_SIZE];
        logic [LIMIT_W-1:0] phase_limits [6];
        logic [LIMIT_W-1:0] cur_limit;
        logic [31:0]        t0;
        logic [31:0]        now;
        logic [63:0]        r;
        logic [ADDR_W-1:0]  addr;
        t_op                op;
        int unsigned        pick;
        int unsigned        i;
        int unsigned        ph;
        int unsigned        n;

        mirror = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, ties, eviction and prune boundary
        t0 = 32'hFFFF_FFF0;
        dir_addr     = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                         48'h0000_0000_0001, 48'h8000_0000_0000, 48'h0123_4567_89AB,
                         48'hCAFE_0000_BEEF};
        dir_strength = '{8'h80, 8'h7F, 8'h00, 8'h7F, 8'hFF, 8'h01, 8'hC0, 8'h10};
        send_item(OP_SELECT, '0, 2'd0, 8'h00, 2'd0, 32'd0);
        pace();
        send_item(OP_PRUNE, '0, 2'd0, 8'h00, 2'd0, 32'd0);
        pace();
        send_item(OP_NONE, 48'hFFFF_FFFF_FFFF, 2'd3, 8'hFF, 2'd3, 32'hFFFF_FFFF);
        pace();
        for (i = 0; i < DEPTH; i++) begin
            send_item(OP_RECORD, dir_addr[i], 2'(i), dir_strength[i], 2'(3 - i % 4), t0);
            pace();
        end
        // update keeps the address type; tie on strength goes to the first slot
        send_item(OP_RECORD, dir_addr[0], 2'd3, 8'h7F, 2'd2, t0);
        pace();
        send_item(OP_SELECT, '0, 2'd0, 8'h00, 2'd0, t0);
        pace();
        // full table with all ages zero replaces slot 0
        send_item(OP_RECORD, 48'h1234_5678_9ABC, 2'd1, 8'h20, 2'd1, t0);
        pace();
        send_item(OP_RECORD, 48'h1234_5678_9ABC, 2'd2, 8'h21, 2'd0, t0 + 32'd10);
        pace();
        send_item(OP_RECORD, 48'hFEDC_BA98_7654, 2'd2, 8'hE0, 2'd3, t0 + 32'd10);
        pace();
        // ages across the 32-bit wrap
        send_item(OP_RECORD, 48'h0F0F_0F0F_0F0F, 2'd3, 8'h40, 2'd2, 32'h0000_0010);
        pace();
        // exactly at the limit is kept, one past it is dropped
        send_item(OP_PRUNE, '0, 2'd0, 8'h00, 2'd0, t0 + 32'd15000);
        pace();
        send_item(OP_PRUNE, '0, 2'd0, 8'h00, 2'd0, t0 + 32'd15001);
        pace();
        send_item(OP_SELECT, '0, 2'd0, 8'h00, 2'd0, t0 + 32'd15001);
        pace();
        send_item(OP_NONE, '0, 2'd0, 8'h00, 2'd0, 32'd0);
        pace();

        phase_limits = '{STALE_RESET, 16'hFFFF, 16'h0000, 16'($urandom_range(1, 4000)),
                         16'd200, 16'd15000};
        now = t0 + 32'd15001;
        for (ph = 0; ph < 6; ph++) begin
            cur_limit = phase_limits[ph];
            if (ph > 0) begin
                settle();
                set_stale_limit(cur_limit);
            end
            for (i = 0; i < POOL_SIZE; i++) begin
                r       = {$urandom, $urandom};
                pool[i] = r[ADDR_W-1:0];
            end
            if (ph == 2)
                now = 32'hFFFF_0000;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // time mostly creeps forward, sometimes lands near the limit or jumps
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    now = now;
                else if (pick < 70)
                    now = now + $urandom_range(1, cur_limit / 8 + 4);
                else if (pick < 85)
                    now = now + cur_limit + $urandom_range(0, 4) - 2;
                else if (pick < 95)
                    now = now + $urandom_range(0, 3 * cur_limit + 10);
                else if (pick < 98)
                    now = now - $urandom_range(1, 1000);
                else
                    now = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 62)
                    op = OP_RECORD;
                else if (pick < 77)
                    op = OP_PRUNE;
                else if (pick < 95)
                    op = OP_SELECT;
                else
                    op = OP_NONE;
                r = {$urandom, $urandom};
                if ($urandom_range(0, 9) == 0)
                    addr = r[ADDR_W-1:0];
                else
                    addr = pool[$urandom_range(0, POOL_SIZE - 1)];
                r = {$urandom, $urandom};
                send_item(op, addr, r[1:0], r[9:2], r[11:10], now);
                pace();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/pct_pkg.sv
hw/rtl/peer_candidate_table.sv
sim/tb.sv
